// File: src/gtfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtfp_pkg
// Shared types and constants of the gyro telemetry frame parser.
// ----------------------------------------------------------------------------
package gtfp_pkg;

	localparam logic [7:0] HDR_TELEM0 = 8'hAA;
	localparam logic [7:0] HDR_TELEM1 = 8'h55;
	localparam logic [7:0] HDR_ACK0   = 8'hA5;
	localparam logic [7:0] HDR_ACK1   = 8'h5B;
	localparam logic [7:0] HDR_SCALE1 = 8'h5C;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [23:0] MILLI_LIMIT = 24'd2147483;
	localparam logic [9:0]  MILLI_SCALE = 10'd1000;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_TELEM_OK  = 3'd1,
		EV_ACK_OK    = 3'd2,
		EV_SCALE_OK  = 3'd3,
		EV_CRC_ERR   = 3'd4,
		EV_FORMAT_ERR = 3'd5,
		EV_HDR_ERR   = 3'd6
	} event_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_HDR  = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		FT_TELEM = 2'd0,
		FT_ACK   = 2'd1,
		FT_SCALE = 2'd2
	} ftype_t;

	// one classified beat, front to back
	typedef struct packed {
		kind_t       kind;
		ftype_t      ftype;
		logic        crc_ok;
		logic        trl_ok;
		logic [15:0] seq;     // telemetry sequence, or ack command/result
		logic [31:0] angle_raw;
		logic [31:0] rate_raw;
	} job_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) c = (c >> 1) ^ CRC_POLY;
			else c = c >> 1;
		end
		return c;
	endfunction

endpackage

// File: src/gtfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtfp_front
// Byte framing: header hunt, running crc and field capture; one job per beat.
// ----------------------------------------------------------------------------
module gtfp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    rx_byte,
	output gtfp_pkg::job_t job
);

	logic [4:0]  pos_q;
	logic        is_aa_q;
	gtfp_pkg::ftype_t ftype_q;
	logic [15:0] crc_q;
	logic [7:0]  crc_lo_q, crc_hi_q;
	logic        trl_ok_q;
	logic [15:0] seq_q;
	logic [31:0] angle_q, rate_q;

	logic [4:0] crc_end, last_pos;
	logic       is_start;

	assign is_start = (rx_byte == gtfp_pkg::HDR_TELEM0) || (rx_byte == gtfp_pkg::HDR_ACK0);

	always_comb begin
		case (ftype_q)
			gtfp_pkg::FT_TELEM: begin crc_end = 5'd11; last_pos = 5'd15; end
			gtfp_pkg::FT_ACK:   begin crc_end = 5'd4;  last_pos = 5'd7;  end
			gtfp_pkg::FT_SCALE: begin crc_end = 5'd8;  last_pos = 5'd11; end
			default:            begin crc_end = 5'd4;  last_pos = 5'd7;  end
		endcase
	end

	always_comb begin
		logic trl_now;
		job = '0;
		job.kind      = gtfp_pkg::KIND_NONE;
		job.ftype     = ftype_q;
		job.seq       = seq_q;
		job.angle_raw = angle_q;
		job.rate_raw  = rate_q;
		job.crc_ok    = (crc_q == {crc_hi_q, crc_lo_q});
		case (ftype_q)
			gtfp_pkg::FT_TELEM: trl_now = (rx_byte == gtfp_pkg::HDR_TELEM0);
			gtfp_pkg::FT_ACK:   trl_now = (rx_byte == gtfp_pkg::HDR_ACK1);
			gtfp_pkg::FT_SCALE: trl_now = (rx_byte == gtfp_pkg::HDR_SCALE1);
			default:            trl_now = 1'b0;
		endcase
		job.trl_ok = trl_ok_q & trl_now;
		if (pos_q == 5'd1) begin
			if (!((is_aa_q && rx_byte == gtfp_pkg::HDR_TELEM1) ||
			      (!is_aa_q && rx_byte == gtfp_pkg::HDR_ACK1) ||
			      (!is_aa_q && rx_byte == gtfp_pkg::HDR_SCALE1)))
				job.kind = gtfp_pkg::KIND_HDR;
		end else if (pos_q >= 5'd2 && pos_q == last_pos) begin
			job.kind = gtfp_pkg::KIND_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			is_aa_q <= 1'b0;
			ftype_q <= gtfp_pkg::FT_TELEM;
		end else if (take) begin
			if (pos_q == 5'd0) begin
				pos_q   <= is_start ? 5'd1 : 5'd0;
				is_aa_q <= (rx_byte == gtfp_pkg::HDR_TELEM0);
			end else if (pos_q == 5'd1) begin
				if (is_aa_q && rx_byte == gtfp_pkg::HDR_TELEM1) begin
					ftype_q <= gtfp_pkg::FT_TELEM;
					pos_q   <= 5'd2;
				end else if (!is_aa_q && rx_byte == gtfp_pkg::HDR_ACK1) begin
					ftype_q <= gtfp_pkg::FT_ACK;
					pos_q   <= 5'd2;
				end else if (!is_aa_q && rx_byte == gtfp_pkg::HDR_SCALE1) begin
					ftype_q <= gtfp_pkg::FT_SCALE;
					pos_q   <= 5'd2;
				end else begin
					// resync on the bad second byte
					pos_q   <= is_start ? 5'd1 : 5'd0;
					is_aa_q <= (rx_byte == gtfp_pkg::HDR_TELEM0);
				end
			end else if (pos_q == last_pos) begin
				pos_q <= 5'd0;
			end else begin
				pos_q <= pos_q + 5'd1;
			end
		end
	end

	// payload-side registers, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			if (pos_q == 5'd1) begin
				crc_q    <= gtfp_pkg::CRC_INIT;
				trl_ok_q <= 1'b1;
			end else if (pos_q >= 5'd2) begin
				if (pos_q <= crc_end) crc_q <= gtfp_pkg::crc_byte(crc_q, rx_byte);
				if (pos_q == crc_end + 5'd1) crc_lo_q <= rx_byte;
				if (pos_q == crc_end + 5'd2) crc_hi_q <= rx_byte;
				if (ftype_q == gtfp_pkg::FT_TELEM && pos_q == 5'd14)
					trl_ok_q <= (rx_byte == gtfp_pkg::HDR_TELEM1);
				case (pos_q)
					5'd2:  seq_q[7:0]     <= rx_byte;
					5'd3:  seq_q[15:8]    <= rx_byte;
					5'd4:  angle_q[7:0]   <= rx_byte;
					5'd5:  angle_q[15:8]  <= rx_byte;
					5'd6:  angle_q[23:16] <= rx_byte;
					5'd7:  angle_q[31:24] <= rx_byte;
					5'd8:  rate_q[7:0]    <= rx_byte;
					5'd9:  rate_q[15:8]   <= rx_byte;
					5'd10: rate_q[23:16]  <= rx_byte;
					5'd11: rate_q[31:24]  <= rx_byte;
					default: ;
				endcase
			end
		end
	end

endmodule

// File: src/gtfp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtfp_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module gtfp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gtfp_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output gtfp_pkg::job_t pop_job
);

	gtfp_pkg::job_t entry_q [gtfp_pkg::FIFO_DEPTH];
	logic [gtfp_pkg::FIFO_AW-1:0] wr_q, rd_q;
	logic [gtfp_pkg::FIFO_AW:0]   cnt_q;

	assign full      = (cnt_q == (gtfp_pkg::FIFO_AW+1)'(gtfp_pkg::FIFO_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_job   = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == (gtfp_pkg::FIFO_AW)'(gtfp_pkg::FIFO_DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == (gtfp_pkg::FIFO_AW)'(gtfp_pkg::FIFO_DEPTH-1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= push_job;
	end

endmodule

// File: src/gtfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtfp_back
// Frame checks, float to milli conversion, held values and counters.
// ----------------------------------------------------------------------------
module gtfp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  gtfp_pkg::job_t job_in,
	output logic           job_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     event_res,
	output logic [15:0]    sequence_res,
	output logic signed [31:0] angle_milli,
	output logic signed [31:0] rate_milli,
	output logic [7:0]     ack_command,
	output logic [7:0]     ack_result,
	output logic [15:0]    dropped_now,
	output logic [31:0]    valid_count,
	output logic [31:0]    crc_error_count,
	output logic [31:0]    format_error_count,
	output logic [31:0]    drop_total,
	output logic [31:0]    ack_count
);

	typedef struct packed {
		logic        bad;
		logic        neg;
		logic        zero;
		logic [5:0]  sh;
		logic [33:0] prod;
	} conv_t;

	function automatic conv_t conv_a(input logic [31:0] raw);
		conv_t       c;
		logic [7:0]  ef;
		logic [23:0] m, q, rem;
		logic [7:0]  s;
		ef = raw[30:23];
		m  = (ef == 8'd0) ? {1'b0, raw[22:0]} : {1'b1, raw[22:0]};
		s  = (ef == 8'd0) ? 8'd149 : 8'd150 - ef;
		q   = m >> s;
		rem = m & ~(24'hFFFFFF << s);
		c.neg  = raw[31];
		c.zero = (s > 8'd35);
		c.sh   = s[5:0];
		c.prod = 34'(m) * 34'(gtfp_pkg::MILLI_SCALE);
		c.bad  = (ef == 8'hFF) || (ef >= 8'd149) ||
		         (!c.zero && (q > gtfp_pkg::MILLI_LIMIT ||
		                      (q == gtfp_pkg::MILLI_LIMIT && rem != '0)));
		return c;
	endfunction

	function automatic logic [31:0] conv_b(input conv_t c);
		logic [36:0] sum;
		logic [31:0] r;
		sum = (37'(c.prod) + (37'd1 << (c.sh - 6'd1))) >> c.sh;
		r   = c.zero ? 32'd0 : sum[31:0];
		return c.neg ? (32'd0 - r) : r;
	endfunction

	// stage 1: multiply and range checks
	logic           valid_s1;
	gtfp_pkg::job_t job_s1;
	conv_t          ca_s1, cg_s1;
	logic           adv;

	assign adv     = valid_s1 && (!out_valid || out_ready);
	assign job_pop = job_valid && (!valid_s1 || adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (!valid_s1 || adv) valid_s1 <= job_valid;
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_s1 <= job_in;
			ca_s1  <= conv_a(job_in.angle_raw);
			cg_s1  <= conv_a(job_in.rate_raw);
		end
	end

	// stage 2: frame verdict and state update
	logic        seen_q;
	logic [15:0] gap;
	logic [2:0]  ev;
	always_comb begin
		gap = job_s1.seq - sequence_res - 16'd1;
		ev  = gtfp_pkg::EV_NONE;
		case (job_s1.kind)
			gtfp_pkg::KIND_HDR: ev = gtfp_pkg::EV_HDR_ERR;
			gtfp_pkg::KIND_DONE: begin
				case (job_s1.ftype)
					gtfp_pkg::FT_TELEM:
						if (!job_s1.crc_ok) ev = gtfp_pkg::EV_CRC_ERR;
						else if (!job_s1.trl_ok || ca_s1.bad || cg_s1.bad)
							ev = gtfp_pkg::EV_FORMAT_ERR;
						else ev = gtfp_pkg::EV_TELEM_OK;
					gtfp_pkg::FT_ACK:
						if (!job_s1.crc_ok) ev = gtfp_pkg::EV_CRC_ERR;
						else if (!job_s1.trl_ok) ev = gtfp_pkg::EV_FORMAT_ERR;
						else ev = gtfp_pkg::EV_ACK_OK;
					gtfp_pkg::FT_SCALE:
						ev = (job_s1.crc_ok && job_s1.trl_ok) ? gtfp_pkg::EV_SCALE_OK
						                                      : gtfp_pkg::EV_CRC_ERR;
					default: ev = gtfp_pkg::EV_FORMAT_ERR;
				endcase
			end
			default: ev = gtfp_pkg::EV_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid          <= 1'b0;
			event_res          <= gtfp_pkg::EV_NONE;
			dropped_now        <= '0;
			seen_q             <= 1'b0;
			sequence_res       <= '0;
			angle_milli        <= '0;
			rate_milli         <= '0;
			ack_command        <= '0;
			ack_result         <= '0;
			valid_count        <= '0;
			crc_error_count    <= '0;
			format_error_count <= '0;
			drop_total         <= '0;
			ack_count          <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (adv) begin
				out_valid   <= 1'b1;
				event_res   <= ev;
				dropped_now <= '0;
				case (ev)
					gtfp_pkg::EV_TELEM_OK: begin
						if (seen_q) begin
							dropped_now <= gap;
							drop_total  <= drop_total + 32'(gap);
						end
						seen_q       <= 1'b1;
						sequence_res <= job_s1.seq;
						angle_milli  <= conv_b(ca_s1);
						rate_milli   <= conv_b(cg_s1);
						valid_count  <= valid_count + 32'd1;
					end
					gtfp_pkg::EV_ACK_OK: begin
						ack_command <= job_s1.seq[7:0];
						ack_result  <= job_s1.seq[15:8];
						ack_count   <= ack_count + 32'd1;
						valid_count <= valid_count + 32'd1;
					end
					gtfp_pkg::EV_SCALE_OK: valid_count <= valid_count + 32'd1;
					gtfp_pkg::EV_CRC_ERR: crc_error_count <= crc_error_count + 32'd1;
					gtfp_pkg::EV_FORMAT_ERR, gtfp_pkg::EV_HDR_ERR:
						format_error_count <= format_error_count + 32'd1;
					default: ;
				endcase
			end
		end
	end

endmodule

// File: src/gyro_telemetry_frame_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_telemetry_frame_parser_top
// Serial frame parser with crc16 check and float to milli conversion.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// input   | in        | in_valid / in_ready   | rx_byte
// result  | out       | out_valid / out_ready | event_res .. ack_count
//
// one byte a cycle sustained while out_ready holds; a taken byte passes the queue,
// the multiply stage and the update stage before its result beat shows
// path: combinational front -> two-entry queue -> multiply stage -> update stage
// reset clears framing, held values and counters at once
// a stalled output backs up the queue, then in_ready drops
// ----------------------------------------------------------------------------
module gyro_telemetry_frame_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [15:0] sequence_res,
	output logic signed [31:0] angle_milli,
	output logic signed [31:0] rate_milli,
	output logic [7:0]  ack_command,
	output logic [7:0]  ack_result,
	output logic [15:0] dropped_now,
	output logic [31:0] valid_count,
	output logic [31:0] crc_error_count,
	output logic [31:0] format_error_count,
	output logic [31:0] drop_total,
	output logic [31:0] ack_count
);

	gtfp_pkg::job_t fr_job, q_job;
	logic full, not_empty, pop, take;

	assign in_ready = !full;
	assign take     = in_valid && in_ready;

	gtfp_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .rx_byte(rx_byte), .job(fr_job)
	);

	gtfp_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(take), .push_job(fr_job), .full(full),
		.pop(pop), .not_empty(not_empty), .pop_job(q_job)
	);

	gtfp_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(not_empty), .job_in(q_job), .job_pop(pop),
		.out_valid(out_valid), .out_ready(out_ready), .event_res(event_res),
		.sequence_res(sequence_res), .angle_milli(angle_milli), .rate_milli(rate_milli),
		.ack_command(ack_command), .ack_result(ack_result), .dropped_now(dropped_now),
		.valid_count(valid_count), .crc_error_count(crc_error_count),
		.format_error_count(format_error_count), .drop_total(drop_total),
		.ack_count(ack_count)
	);

endmodule

// File: src/gtfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtfp_checker
// Port-level checks of the frame parser.
// ----------------------------------------------------------------------------
module gtfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  event_res,
	input logic [15:0] dropped_now,
	input logic [31:0] valid_count,
	input logic [31:0] ack_count
);

	// stalled beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res))
		else $error("result beat changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_res <= gtfp_pkg::EV_HDR_ERR)
		else $error("event code out of range");

	// a gap only shows with a good telemetry frame
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped_now != 16'd0 |-> event_res == gtfp_pkg::EV_TELEM_OK)
		else $error("gap without telemetry");

	// ack count moves only with an ack, and valid count with it
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ack_count != $past(ack_count) |->
			event_res == gtfp_pkg::EV_ACK_OK && valid_count != $past(valid_count))
		else $error("ack count moved without an ack");

endmodule

bind gyro_telemetry_frame_parser_top gtfp_checker u_gtfp_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.event_res(event_res), .dropped_now(dropped_now), .valid_count(valid_count),
	.ack_count(ack_count)
);

// File: verif/gyro_telemetry_frame_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_telemetry_frame_parser_top_tb
// Feeds byte streams of telemetry, ack and scale frames, broken frames and
// noise into the parser and checks every result beat against a predictor.
// ----------------------------------------------------------------------------
module gyro_telemetry_frame_parser_top_tb;

	typedef struct {
		gtfp_pkg::event_t ev;
		logic [15:0] seq;
		logic [31:0] angle;
		logic [31:0] rate;
		logic [7:0]  cmd;
		logic [7:0]  res;
		logic [15:0] gap;
		logic [31:0] n_valid;
		logic [31:0] n_crc;
		logic [31:0] n_format;
		logic [31:0] n_drop;
		logic [31:0] n_ack;
	} parse_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  event_res;
	logic [15:0] sequence_res;
	logic signed [31:0] angle_milli;
	logic signed [31:0] rate_milli;
	logic [7:0]  ack_command;
	logic [7:0]  ack_result;
	logic [15:0] dropped_now;
	logic [31:0] valid_count;
	logic [31:0] crc_error_count;
	logic [31:0] format_error_count;
	logic [31:0] drop_total;
	logic [31:0] ack_count;

	gyro_telemetry_frame_parser_top u_top (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [7:0]  fbuf [16];
	int unsigned fpos;
	int unsigned flen;
	bit          seq_seen;
	logic [15:0] seq_last;
	logic [31:0] angle_last;
	logic [31:0] rate_last;
	logic [7:0]  cmd_last;
	logic [7:0]  res_last;
	logic [31:0] cnt_valid, cnt_crc, cnt_format, cnt_drop, cnt_ack;

	parse_result_t expected_q [$];
	int errors = 0;
	longint cycles = 0;
	bit hold_off = 1'b0;
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;

	function automatic logic [15:0] modbus_crc(input logic [7:0] d [], input int n);
		logic [15:0] c;
		c = 16'hFFFF;
		for (int i = 0; i < n; i++) begin
			c ^= {8'h00, d[i]};
			for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [15:0] buf_crc(input int first, input int n);
		logic [7:0] d [];
		d = new[n];
		for (int i = 0; i < n; i++) d[i] = fbuf[(first + i) & 15];
		return modbus_crc(d, n);
	endfunction

	function automatic logic [15:0] buf16(input int at);
		return {fbuf[(at + 1) & 15], fbuf[at & 15]};
	endfunction

	// exact single to milli units, half away from zero
	function automatic bit float_milli(input logic [31:0] raw, output logic [31:0] res);
		int unsigned ef;
		logic [63:0] m, r;
		int unsigned s;
		ef = raw[30:23];
		m = {41'd0, raw[22:0]};
		res = 32'd0;
		if (ef == 255 || ef >= 149) return 1'b0;
		if (ef == 0) s = 149;
		else begin
			m[23] = 1'b1;
			s = 150 - ef;
		end
		if (s > 35) r = 64'd0;
		else begin
			if (m > (64'd2147483 << s)) return 1'b0;
			r = (m * 64'd1000 + (64'd1 << (s - 1))) >> s;
		end
		res = raw[31] ? -r[31:0] : r[31:0];
		return 1'b1;
	endfunction

	function automatic void rescan(input logic [7:0] b);
		fpos = 0;
		flen = 0;
		if (b == gtfp_pkg::HDR_TELEM0 || b == gtfp_pkg::HDR_ACK0) begin
			fbuf[0] = b;
			fpos = 1;
		end
	endfunction

	function automatic gtfp_pkg::event_t close_frame(output logic [15:0] gap);
		logic [31:0] a, g;
		logic [15:0] sq;
		gap = 16'd0;
		if (fbuf[0] == gtfp_pkg::HDR_TELEM0 && flen == 16) begin
			if (buf16(12) != buf_crc(2, 10)) begin
				cnt_crc++;
				return gtfp_pkg::EV_CRC_ERR;
			end
			if (fbuf[14] != gtfp_pkg::HDR_TELEM1 || fbuf[15] != gtfp_pkg::HDR_TELEM0 ||
					!float_milli({buf16(6), buf16(4)}, a) ||
					!float_milli({buf16(10), buf16(8)}, g)) begin
				cnt_format++;
				return gtfp_pkg::EV_FORMAT_ERR;
			end
			sq = buf16(2);
			if (seq_seen) begin
				gap = sq - seq_last - 16'd1;
				cnt_drop += {16'd0, gap};
			end
			seq_seen = 1'b1;
			seq_last = sq;
			angle_last = a;
			rate_last = g;
			cnt_valid++;
			return gtfp_pkg::EV_TELEM_OK;
		end
		if (fbuf[0] == gtfp_pkg::HDR_ACK0 && fbuf[1] == gtfp_pkg::HDR_ACK1 && flen == 8) begin
			if (buf16(5) != buf_crc(2, 3)) begin
				cnt_crc++;
				return gtfp_pkg::EV_CRC_ERR;
			end
			if (fbuf[7] != gtfp_pkg::HDR_ACK1) begin
				cnt_format++;
				return gtfp_pkg::EV_FORMAT_ERR;
			end
			cmd_last = fbuf[2];
			res_last = fbuf[3];
			cnt_ack++;
			cnt_valid++;
			return gtfp_pkg::EV_ACK_OK;
		end
		if (fbuf[0] == gtfp_pkg::HDR_ACK0 && fbuf[1] == gtfp_pkg::HDR_SCALE1 && flen == 12) begin
			if (fbuf[11] == gtfp_pkg::HDR_SCALE1 && buf16(9) == buf_crc(2, 7)) begin
				cnt_valid++;
				return gtfp_pkg::EV_SCALE_OK;
			end
			cnt_crc++;
			return gtfp_pkg::EV_CRC_ERR;
		end
		cnt_format++;
		return gtfp_pkg::EV_FORMAT_ERR;
	endfunction

	function automatic parse_result_t parse_byte(input logic [7:0] b);
		parse_result_t r;
		gtfp_pkg::event_t ev;
		logic [15:0] gap;
		bit ok;
		ev = gtfp_pkg::EV_NONE;
		gap = 16'd0;
		ok = 1'b1;
		if (fpos == 0) rescan(b);
		else begin
			if (fpos == 1) begin
				if (fbuf[0] == gtfp_pkg::HDR_TELEM0 && b == gtfp_pkg::HDR_TELEM1) flen = 16;
				else if (fbuf[0] == gtfp_pkg::HDR_ACK0 && b == gtfp_pkg::HDR_ACK1) flen = 8;
				else if (fbuf[0] == gtfp_pkg::HDR_ACK0 && b == gtfp_pkg::HDR_SCALE1) flen = 12;
				else begin
					cnt_format++;
					ev = gtfp_pkg::EV_HDR_ERR;
					rescan(b);
					ok = 1'b0;
				end
			end
			if (ok) begin
				fbuf[fpos & 15] = b;
				fpos++;
				if (fpos >= flen || fpos >= 16) begin
					ev = close_frame(gap);
					rescan(8'h00);
				end
			end
		end
		r.ev = ev;
		r.seq = seq_last;
		r.angle = angle_last;
		r.rate = rate_last;
		r.cmd = cmd_last;
		r.res = res_last;
		r.gap = gap;
		r.n_valid = cnt_valid;
		r.n_crc = cnt_crc;
		r.n_format = cnt_format;
		r.n_drop = cnt_drop;
		r.n_ack = cnt_ack;
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic idle_gap();
		int n;
		if (!send_idle) return;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
		repeat (n) @(negedge clk);
	endtask

	// one byte beat; valid stays high back to back unless a random idle gap follows
	task automatic send_byte(input logic [7:0] b);
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(parse_byte(b));
		@(negedge clk);
		if (send_idle && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			idle_gap();
		end
	endtask

	task automatic send_seq(input logic [7:0] d [$]);
		foreach (d[i]) send_byte(d[i]);
	endtask

	function automatic logic [31:0] rand_float();
		case ($urandom_range(0, 7))
			0: return $urandom();
			1: return {1'($urandom()), 8'hFF, 23'($urandom())};
			2: return {1'($urandom()), 8'd0, 23'($urandom())};
			3: return {1'($urandom()), 8'($urandom_range(147, 148)), 23'($urandom())};
			default: return {1'($urandom()), 8'($urandom_range(100, 148)), 23'($urandom())};
		endcase
	endfunction

	function automatic void put_crc(ref logic [7:0] f [$], input int first, input int n);
		logic [7:0] d [];
		logic [15:0] c;
		d = new[n];
		for (int i = 0; i < n; i++) d[i] = f[first + i];
		c = modbus_crc(d, n);
		f.push_back(c[7:0]);
		f.push_back(c[15:8]);
	endfunction

	function automatic void telem_frame(ref logic [7:0] f [$], input logic [15:0] sq,
			input logic [31:0] a, input logic [31:0] g);
		f = {gtfp_pkg::HDR_TELEM0, gtfp_pkg::HDR_TELEM1, sq[7:0], sq[15:8],
			a[7:0], a[15:8], a[23:16], a[31:24],
			g[7:0], g[15:8], g[23:16], g[31:24]};
		put_crc(f, 2, 10);
		f.push_back(gtfp_pkg::HDR_TELEM1);
		f.push_back(gtfp_pkg::HDR_TELEM0);
	endfunction

	function automatic void ack_frame(ref logic [7:0] f [$], input logic [7:0] c,
			input logic [7:0] r);
		f = {gtfp_pkg::HDR_ACK0, gtfp_pkg::HDR_ACK1, c, r, 8'($urandom())};
		put_crc(f, 2, 3);
		f.push_back(gtfp_pkg::HDR_ACK1);
	endfunction

	function automatic void scale_frame(ref logic [7:0] f [$]);
		f = {gtfp_pkg::HDR_ACK0, gtfp_pkg::HDR_SCALE1};
		repeat (7) f.push_back(8'($urandom()));
		put_crc(f, 2, 7);
		f.push_back(gtfp_pkg::HDR_SCALE1);
	endfunction

	// corrupt one byte past the header sometimes
	function automatic void maybe_break(ref logic [7:0] f [$]);
		int k;
		if ($urandom_range(0, 4) != 0 || f.size() < 3) return;
		k = $urandom_range(2, f.size() - 1);
		f[k] = f[k] ^ 8'(1 << $urandom_range(0, 7));
	endfunction

	task automatic test_directed();
		logic [7:0] f [$];
		send_seq('{8'h00, 8'hFF, 8'h12});                          // hunting drops noise
		send_seq('{gtfp_pkg::HDR_TELEM0, 8'h00});                  // bad second byte
		send_seq('{gtfp_pkg::HDR_ACK0, gtfp_pkg::HDR_TELEM0, 8'h54}); // bad byte restarts
		telem_frame(f, 16'h0005, 32'h3F80_0000, 32'hBFC0_0000);
		send_seq(f);                                     // first telemetry, no gap
		telem_frame(f, 16'h0009, 32'h4A03_1260, 32'h0000_0001);
		send_seq(f);
		telem_frame(f, 16'h0000, 32'h7F80_0000, 32'h0);  // infinity
		send_seq(f);
		telem_frame(f, 16'hFFFF, 32'h4B00_0000, 32'h0);  // too large
		send_seq(f);
		telem_frame(f, 16'hFFFF, 32'hCA03_1260, 32'h8000_0000);
		f[14] = 8'h00;                                   // bad trailer
		send_seq(f);
		telem_frame(f, 16'h0000, 32'h3A83_126F, 32'hBA83_126F);
		send_seq(f);                                     // gap wraps
		telem_frame(f, 16'h1234, 32'h0, 32'h0);
		f[12] = ~f[12];
		send_seq(f);                                     // crc error
		ack_frame(f, 8'hFF, 8'h00);
		send_seq(f);
		ack_frame(f, 8'h00, 8'hFF);
		f[7] = 8'h00;
		send_seq(f);                                     // ack trailer
		ack_frame(f, 8'h11, 8'h22);
		f[5] = ~f[5];
		send_seq(f);                                     // ack crc
		scale_frame(f);
		send_seq(f);
		scale_frame(f);
		f[11] = 8'h00;
		send_seq(f);                                     // scale trailer
	endtask

	task automatic test_random(input int n_items);
		logic [7:0] f [$];
		int sent;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: telem_frame(f, seq_last + 16'($urandom_range(1, 3)) -
						16'($urandom_range(0, 1) * 2), rand_float(), rand_float());
				4, 5: ack_frame(f, 8'($urandom()), 8'($urandom()));
				6: scale_frame(f);
				7: f = {gtfp_pkg::HDR_TELEM0, 8'($urandom()), 8'($urandom())};
				8: f = {gtfp_pkg::HDR_ACK0, 8'($urandom())};
				default: begin
					f = {};
					repeat ($urandom_range(1, 6)) f.push_back(8'($urandom()));
				end
			endcase
			maybe_break(f);
			if ($urandom_range(0, 7) == 0) f = f[0:$urandom_range(0, f.size() - 1)];
			send_seq(f);
			sent += f.size();
		end
	endtask

	task automatic test_backpressure();
		logic [7:0] f [$];
		hold_off = 1'b1;
		send_idle = 1'b0;
		fork
			begin
				repeat (60) @(negedge clk);
				hold_off = 1'b0;
			end
			repeat (3) begin
				telem_frame(f, seq_last + 16'd1, rand_float(), rand_float());
				send_seq(f);
			end
		join
		send_idle = 1'b1;
	endtask

	task automatic test_back_to_back();
		logic [7:0] f [$];
		send_idle = 1'b0;
		recv_idle = 1'b0;
		repeat (8) begin
			ack_frame(f, 8'($urandom()), 8'($urandom()));
			send_seq(f);
		end
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	// receiver side
	always @(negedge clk) begin
		if (!arst_n || hold_off) out_ready <= 1'b0;
		else if (!recv_idle) out_ready <= 1'b1;
		else if ($urandom_range(0, 29) == 0) out_ready <= 1'b0;
		else if (!out_ready && $urandom_range(0, 3) != 0) out_ready <= 1'b0;
		else out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		parse_result_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("unexpected result beat at %0t", $realtime);
				errors++;
			end else begin
				w = expected_q.pop_front();
				if (event_res !== w.ev) report("event_res", event_res, w.ev);
				if (sequence_res !== w.seq) report("sequence_res", sequence_res, w.seq);
				if (angle_milli !== w.angle) report("angle_milli", angle_milli, w.angle);
				if (rate_milli !== w.rate) report("rate_milli", rate_milli, w.rate);
				if (ack_command !== w.cmd) report("ack_command", ack_command, w.cmd);
				if (ack_result !== w.res) report("ack_result", ack_result, w.res);
				if (dropped_now !== w.gap) report("dropped_now", dropped_now, w.gap);
				if (valid_count !== w.n_valid) report("valid_count", valid_count, w.n_valid);
				if (crc_error_count !== w.n_crc)
					report("crc_error_count", crc_error_count, w.n_crc);
				if (format_error_count !== w.n_format)
					report("format_error_count", format_error_count, w.n_format);
				if (drop_total !== w.n_drop) report("drop_total", drop_total, w.n_drop);
				if (ack_count !== w.n_ack) report("ack_count", ack_count, w.n_ack);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 200000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		fpos = 0;
		flen = 0;
		seq_seen = 1'b0;
		seq_last = '0;
		angle_last = '0;
		rate_last = '0;
		cmd_last = '0;
		res_last = '0;
		{cnt_valid, cnt_crc, cnt_format, cnt_drop, cnt_ack} = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_back_to_back();
		test_random(320);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
